/* rtl/key_click_event_detector_defines.svh */
// Assertion macros used by the checker of the key click event detector.
`ifndef KEY_CLICK_EVENT_DETECTOR_DEFINES_SVH
`define KEY_CLICK_EVENT_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCED_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KCED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/kced_pkg.sv */
package kced_pkg;

  localparam int unsigned HistoryLen = 32;
  localparam int unsigned CntW       = 16;
  localparam int unsigned EventW     = 3;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  typedef enum logic [EventW-1:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_REPEAT = 3'd4
  } kced_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LONG_PRESS   = 2'd0,
    REG_REPEAT_PER   = 2'd1,
    REG_DBL_WINDOW   = 2'd2,
    REG_MIN_RELEASE  = 2'd3
  } kced_reg_e;

  // Thresholds as seen by the state machine.
  typedef struct packed {
    logic [CntW-1:0] long_press_ticks;
    logic [CntW-1:0] repeat_period_ticks;
    logic [CntW-1:0] double_click_window_ticks;
    logic [CntW-1:0] min_release_ticks;
  } kced_cfg_t;

  // Debouncer status for the tick being processed.
  typedef struct packed {
    logic all_on;
    logic all_off;
  } kced_hist_t;

  // Saturating tick counter increment.
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + CntW'(1);
  endfunction

endpackage

/* rtl/kced_debounce.sv */
module kced_debounce (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               level_i,
  output kced_pkg::kced_hist_t hist_o,
  output logic               stable_d_o
);
  import kced_pkg::*;

  logic [HistoryLen-1:0] hist_q, hist_d;
  logic                  debounced_q, debounced_d;

  assign hist_d = {hist_q[HistoryLen-2:0], level_i};

  assign hist_o.all_on  = &hist_d;
  assign hist_o.all_off = ~|hist_d;

  always_comb begin
    debounced_d = debounced_q;
    if (hist_o.all_on) begin
      debounced_d = 1'b1;
    end
    if (hist_o.all_off) begin
      debounced_d = 1'b0;
    end
  end

  assign stable_d_o = debounced_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      debounced_q <= 1'b0;
    end else if (step_i) begin
      hist_q      <= hist_d;
      debounced_q <= debounced_d;
    end
  end

endmodule

/* rtl/kced_fsm.sv */
module kced_fsm (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  kced_pkg::kced_cfg_t   cfg_i,
  input  kced_pkg::kced_hist_t  hist_i,
  output kced_pkg::kced_event_e event_d_o
);
  import kced_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_PRESSED = 5'b00010,
    ST_LONG    = 5'b00100,
    ST_WAIT    = 5'b01000,
    ST_SECOND  = 5'b10000
  } kced_state_e;

  kced_state_e     state_q, state_d;
  logic [CntW-1:0] press_q, press_d;
  logic [CntW-1:0] release_q, release_d;
  logic [CntW-1:0] window_q, window_d;
  logic [CntW-1:0] repeat_q, repeat_d;
  logic            long_done_q, long_done_d;
  kced_event_e     ev;

  always_comb begin
    state_d     = state_q;
    press_d     = press_q;
    release_d   = release_q;
    window_d    = window_q;
    repeat_d    = repeat_q;
    long_done_d = long_done_q;
    ev          = EV_NONE;

    case (state_q)
      ST_IDLE: begin
        if (hist_i.all_on) begin
          state_d     = ST_PRESSED;
          press_d     = '0;
          long_done_d = 1'b0;
        end
      end
      ST_PRESSED: begin
        press_d = sat_inc(press_q);
        if ((press_d >= cfg_i.long_press_ticks) && !long_done_q) begin
          state_d     = ST_LONG;
          ev          = EV_LONG;
          long_done_d = 1'b1;
          repeat_d    = '0;
        end
        // A release in the same tick still wins the next state.
        if (hist_i.all_off) begin
          state_d   = ST_WAIT;
          window_d  = '0;
          release_d = '0;
        end
      end
      ST_LONG: begin
        repeat_d = sat_inc(repeat_q);
        if (repeat_d >= cfg_i.repeat_period_ticks) begin
          repeat_d = '0;
          ev       = EV_REPEAT;
        end
        if (hist_i.all_off) begin
          state_d  = ST_IDLE;
          repeat_d = '0;
        end
      end
      ST_WAIT: begin
        window_d = sat_inc(window_q);
        if (hist_i.all_off) begin
          release_d = sat_inc(release_q);
        end
        if (window_d >= cfg_i.double_click_window_ticks) begin
          state_d = ST_IDLE;
          ev      = EV_SINGLE;
        end
        // The single click may still be reported while entering second press.
        if (hist_i.all_on && (release_d >= cfg_i.min_release_ticks)) begin
          state_d = ST_SECOND;
        end
      end
      ST_SECOND: begin
        if (hist_i.all_off) begin
          state_d = ST_IDLE;
          ev      = EV_DOUBLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign event_d_o = ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      press_q     <= '0;
      release_q   <= '0;
      window_q    <= '0;
      repeat_q    <= '0;
      long_done_q <= 1'b0;
    end else if (step_i) begin
      state_q     <= state_d;
      press_q     <= press_d;
      release_q   <= release_d;
      window_q    <= window_d;
      repeat_q    <= repeat_d;
      long_done_q <= long_done_d;
    end
  end

endmodule

/* rtl/key_click_event_detector.sv */
// Channel   Direction  Signals                                   Beat
// in        input      in_valid_i, in_ready_o, level_i           one sampled level (one tick)
// out       output     out_valid_o, out_ready_i, event_res_o,    one event code and the
//                      stable_level_o                            debounced level
// cfg       input      cfg_valid_i, cfg_ready_o, cfg_index_i,    one threshold register write
//                      cfg_data_i
//
// Every input beat produces exactly one output beat, in the cycle after acceptance: the
// history, debounced level and click state machine update at the accepting edge.
// Sustained rate is one beat per cycle, since the single output register is refilled
// in the same cycle it is drained. When the output beat is stalled, in_ready_o drops
// and the block holds all state. Reset (rst_ni, asynchronous, active low) clears the
// history and click state, empties the output register and loads default thresholds.
module key_click_event_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         level_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [kced_pkg::EventW-1:0]  event_res_o,
  output logic                         stable_level_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kced_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [kced_pkg::CntW-1:0]    cfg_data_i
);
  import kced_pkg::*;

  kced_cfg_t   cfg_q;
  kced_hist_t  hist;
  kced_event_e event_d;
  logic        stable_d;
  logic        step;
  logic        out_valid_q;
  kced_event_e event_q;
  logic        stable_q;

  // The output register can take a new result whenever it is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  // The configuration port always accepts; registers should be written while idle.
  assign cfg_ready_o = 1'b1;

  // Threshold registers. All four indexes are defined, so every write lands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks          <= CntW'(1000);
      cfg_q.repeat_period_ticks       <= CntW'(200);
      cfg_q.double_click_window_ticks <= CntW'(300);
      cfg_q.min_release_ticks         <= CntW'(20);
    end else if (cfg_valid_i) begin
      case (kced_reg_e'(cfg_index_i))
        REG_LONG_PRESS:  cfg_q.long_press_ticks          <= cfg_data_i;
        REG_REPEAT_PER:  cfg_q.repeat_period_ticks       <= cfg_data_i;
        REG_DBL_WINDOW:  cfg_q.double_click_window_ticks <= cfg_data_i;
        REG_MIN_RELEASE: cfg_q.min_release_ticks         <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  kced_debounce u_debounce (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .level_i    (level_i),
    .hist_o     (hist),
    .stable_d_o (stable_d)
  );

  kced_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .cfg_i     (cfg_q),
    .hist_i    (hist),
    .event_d_o (event_d)
  );

  // Output register: valid is control, the payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      event_q  <= event_d;
      stable_q <= stable_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = event_q;
  assign stable_level_o = stable_q;

endmodule

/* rtl/kced_checker.sv */
`include "key_click_event_detector_defines.svh"

module kced_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [kced_pkg::EventW-1:0]  event_res_o,
  input logic                         stable_level_o
);
  import kced_pkg::*;

  // A stalled result beat keeps its payload.
  `KCED_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(event_res_o) && $stable(stable_level_o), "out beat changed while stalled")

  // Every accepted tick yields a result in the next cycle.
  `KCED_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_valid_i && in_ready_o,
    out_valid_o, "accepted tick produced no result")

  // Input back-pressure only comes from a stalled output.
  `KCED_ASSERT_IMPL(a_ready_cause, clk_i, rst_ni, !in_ready_o,
    out_valid_o && !out_ready_i, "input stalled without output stall")

  // A double click is reported on the tick the level settles released.
  `KCED_ASSERT_IMPL(a_double_released, clk_i, rst_ni,
    out_valid_o && (event_res_o == EV_DOUBLE), !stable_level_o,
    "double click with pressed level")

endmodule

bind key_click_event_detector kced_checker u_kced_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .event_res_o    (event_res_o),
  .stable_level_o (stable_level_o)
);
